// ----- hdl/clock_second_chance_victim_unit_macros.svh -----
// Assertion macros for the clock second-chance victim unit datapath.
`ifndef CLOCK_SECOND_CHANCE_VICTIM_UNIT_MACROS_SVH
`define CLOCK_SECOND_CHANCE_VICTIM_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked property, masked while reset is high
`define CSCV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also during reset
`define CSCV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSCV_ASSERT(lbl, clk, rst, prop, msg)
`define CSCV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hdl/cscv_pkg.sv -----
// Shared constants and controller/datapath interface types for the victim unit.
package cscv_pkg;

   localparam int MAX_FRAMES = 64;
   localparam int FRAME_W    = $clog2(MAX_FRAMES);
   localparam int CNT_W      = FRAME_W + 1;
   localparam int STEP_W     = FRAME_W + 2;

   // Operation codes of an input word
   localparam logic OP_REFERENCE = 1'b0;
   localparam logic OP_VICTIM    = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic ref_write;   // set the used bit of the referenced frame
      logic start;       // begin a sweep: clear step count, wrap a stale hand
      logic clear_step;  // clear used bit under the hand and advance
      logic emit;        // load the frame under the hand as victim and advance
   } cscv_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic used;        // used bit under the hand
      logic bound_hit;   // sweep has taken twice the frame count steps
      logic out_free;    // result register can take a word this cycle
   } cscv_status_type;

endpackage

// ----- hdl/cscv_ctrl.sv -----
// Sequencing state machine for reference and victim-search words.
module cscv_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_operation,
   input  cscv_pkg::cscv_status_type status,
   output cscv_pkg::cscv_cmd_type    cmd
);
   import cscv_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SWEEP = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_REFERENCE) begin
                  cmd.ref_write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            // a set bit gets its second chance; a clear one (or the bound) ends the sweep
            if (status.used && !status.bound_hit) begin
               cmd.clear_step = 1'b1;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/cscv_datapath.sv -----
// Used bits, hand, frame count register, step counter and result register.
`include "clock_second_chance_victim_unit_macros.svh"
module cscv_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cscv_pkg::FRAME_W-1:0]      req_frame_index,
   input  logic                              csr_valid,
   input  logic [cscv_pkg::CNT_W-1:0]        csr_frames_in_use,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cscv_pkg::FRAME_W-1:0]      rsp_victim_frame,
   input  cscv_pkg::cscv_cmd_type            cmd,
   output cscv_pkg::cscv_status_type         status
);
   import cscv_pkg::*;

   logic [MAX_FRAMES-1:0] used_ff, used_in;
   logic [FRAME_W-1:0]    hand_ff, hand_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [STEP_W-1:0]     steps_ff, steps_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]    victim_ff, victim_in;

   logic [CNT_W-1:0]      hand_plus;
   logic [FRAME_W-1:0]    hand_next;

   // Hand advance with wrap at the frame count
   assign hand_plus = {1'b0, hand_ff} + CNT_W'(1);
   assign hand_next = (hand_plus >= count_ff) ? '0 : hand_plus[FRAME_W-1:0];

   assign status.used      = used_ff[hand_ff];
   assign status.bound_hit = (steps_ff == {count_ff, 1'b0});
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Frame count write, clamped to 1..MAX_FRAMES
   always_comb begin
      count_in = count_ff;
      if (csr_valid) begin
         if (csr_frames_in_use == '0) begin
            count_in = CNT_W'(1);
         end else if (csr_frames_in_use > CNT_W'(MAX_FRAMES)) begin
            count_in = CNT_W'(MAX_FRAMES);
         end else begin
            count_in = csr_frames_in_use;
         end
      end
   end

   // Used bits, hand and step count
   always_comb begin
      used_in  = used_ff;
      hand_in  = hand_ff;
      steps_in = steps_ff;
      if (cmd.ref_write && ({1'b0, req_frame_index} < count_ff)) begin
         used_in[req_frame_index] = 1'b1;
      end
      if (cmd.start) begin
         steps_in = '0;
         if ({1'b0, hand_ff} >= count_ff) begin
            hand_in = '0;
         end
      end
      if (cmd.clear_step) begin
         used_in[hand_ff] = 1'b0;
         hand_in          = hand_next;
         steps_in         = steps_ff + STEP_W'(1);
      end
      // step count goes back to zero so it stays inside the bound of a later frame count
      if (cmd.emit) begin
         hand_in  = hand_next;
         steps_in = '0;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      victim_in    = victim_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         victim_in    = hand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         hand_ff      <= '0;
         count_ff     <= CNT_W'(MAX_FRAMES);
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         hand_ff      <= hand_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      victim_ff <= victim_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_victim_frame = victim_ff;

   `CSCV_ASSERT(a_count_range, clock, reset, (count_ff != '0) && (count_ff <= CNT_W'(MAX_FRAMES)), "frame count out of range")
   `CSCV_ASSERT(a_emit_free, clock, reset, cmd.emit |-> (!rsp_valid_ff || rsp_ready), "victim overwrote a pending result")
   `CSCV_ASSERT(a_clear_done, clock, reset, cmd.clear_step |=> !used_ff[$past(hand_ff)], "second-chance bit not cleared")
   `CSCV_ASSERT(a_step_bound, clock, reset, steps_ff <= {count_ff, 1'b0}, "sweep ran past its bound")

endmodule

// ----- hdl/clock_second_chance_victim_unit.sv -----
// Clock second-chance victim unit: a reference word sets the used bit of its
// frame if in range; a victim word sweeps from the hand one frame per cycle,
// clearing set used bits (at most the frame count); emits when output is free.
// The next word is taken once the previous one is finished; a result waits in
// an output register. Synchronous reset clears all used bits, the hand and the
// result valid, and sets the frame count to 64.
module clock_second_chance_victim_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [cscv_pkg::FRAME_W-1:0]  req_frame_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cscv_pkg::FRAME_W-1:0]  rsp_victim_frame,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cscv_pkg::CNT_W-1:0]    csr_frames_in_use
);
   import cscv_pkg::*;

   cscv_cmd_type    cmd;
   cscv_status_type status;

   assign csr_ready = 1'b1;

   // Sequencer
   cscv_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   // Frame state and result register
   cscv_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_frame_index   (req_frame_index),
      .csr_valid         (csr_valid),
      .csr_frames_in_use (csr_frames_in_use),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_victim_frame  (rsp_victim_frame),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// ----- dv/clock_second_chance_victim_unit_tb.sv -----
// Self-checking testbench for the clock second-chance victim unit.

// Tracks used bits and the hand; holds the victim frames still owed by the block
class victim_scoreboard;
   bit                           used_map [cscv_pkg::MAX_FRAMES];
   int unsigned                  hand_pos;
   int unsigned                  live_frames;
   logic [cscv_pkg::FRAME_W-1:0] victim_q [$];
   int                           fault_count;
   int                           victim_words;
   int                           ref_words;

   function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      hand_pos     = 0;
      live_frames  = cscv_pkg::MAX_FRAMES;
      fault_count  = 0;
      victim_words = 0;
      ref_words    = 0;
   endfunction

   // Frame count register; zero acts as one, above the maximum clamps
   function void set_frames(logic [cscv_pkg::CNT_W-1:0] raw);
      if (raw == 0)
         live_frames = 1;
      else if (raw > cscv_pkg::MAX_FRAMES)
         live_frames = cscv_pkg::MAX_FRAMES;
      else
         live_frames = 32'(raw);
   endfunction

   function int unsigned frames();
      return live_frames;
   endfunction

   function int pending();
      return victim_q.size();
   endfunction

   // Accepted input word: reference sets a used bit, victim request sweeps
   function void note_input(logic op, logic [cscv_pkg::FRAME_W-1:0] idx);
      int unsigned                  pos;
      int unsigned                  steps;
      bit                           found;
      logic [cscv_pkg::FRAME_W-1:0] victim;
      if (op == cscv_pkg::OP_REFERENCE) begin
         ref_words++;
         // frames beyond the live count are ignored
         if (idx < live_frames) used_map[idx] = 1'b1;
         return;
      end
      victim_words++;
      found  = 1'b0;
      steps  = 0;
      victim = '0;
      pos    = hand_pos;
      // a hand left past a shrunken count restarts at frame 0
      if (pos >= live_frames) pos = 0;
      while (!found && steps < 2 * live_frames) begin
         if (used_map[pos]) begin
            used_map[pos] = 1'b0;
         end else begin
            victim = pos[cscv_pkg::FRAME_W-1:0];
            found  = 1'b1;
         end
         pos = (pos + 1 >= live_frames) ? 0 : pos + 1;
         steps++;
      end
      // forced victim if the sweep bound were ever hit
      if (!found) begin
         victim = pos[cscv_pkg::FRAME_W-1:0];
         pos    = (pos + 1 >= live_frames) ? 0 : pos + 1;
      end
      hand_pos = pos;
      victim_q.push_back(victim);
   endfunction

   // Accepted result word against the oldest owed victim
   function void check_result(logic [cscv_pkg::FRAME_W-1:0] got);
      logic [cscv_pkg::FRAME_W-1:0] want;
      if (victim_q.size() == 0) begin
         fault_count++;
         if (fault_count <= 10)
            $display("unexpected result word: victim_frame %0d", got);
         return;
      end
      want = victim_q.pop_front();
      if (got !== want) begin
         fault_count++;
         if (fault_count <= 10)
            $display("victim_frame mismatch: expected %0d, got %0d", want, got);
      end
   endfunction
endclass

module clock_second_chance_victim_unit_tb;
   import cscv_pkg::*;

   localparam int QUIET_CYCLES = 10;
   localparam int DRAIN_TAIL   = 80;   // longest sweep plus margin
   localparam int LONG_HOLD    = 400;
   localparam int SEG_WORDS    = 150;
   localparam int VICTIM_PCT   = 30;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic               req_operation     = OP_REFERENCE;
   logic [FRAME_W-1:0] req_frame_index   = '0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic [FRAME_W-1:0] rsp_victim_frame;
   logic               csr_valid         = 1'b0;
   logic               csr_ready;
   logic [CNT_W-1:0]   csr_frames_in_use = '0;

   int                 send_idle_pct     = 29;
   int                 recv_idle_pct     = 45;
   logic               hold_active       = 1'b0;
   int                 csr_writes        = 0;
   event               stall_go;
   victim_scoreboard   sb;

   clock_second_chance_victim_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_frame_index  (req_frame_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_victim_frame (rsp_victim_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_frames_in_use(csr_frames_in_use)
   );

   // 10-unit clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Result side: check accepted words, randomize ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_victim_frame);
      if (hold_active)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Long back-pressure stretch, counted here
   always begin
      @(stall_go);
      hold_active <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      hold_active <= 1'b0;
   end

   // Offer one input word after random idle cycles
   task automatic send_word(input logic op, input logic [FRAME_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_frame_index <= idx;
      do @(posedge clock); while (!req_ready);
      sb.note_input(op, idx);
   endtask

   // Random word: mostly references, mostly within the live frames
   task automatic send_random();
      logic               op;
      logic [FRAME_W-1:0] idx;
      op = ($urandom_range(99) < VICTIM_PCT) ? OP_VICTIM : OP_REFERENCE;
      if ($urandom_range(9) < 8)
         idx = FRAME_W'($urandom_range(sb.frames() - 1));
      else
         idx = FRAME_W'($urandom_range(MAX_FRAMES - 1));
      send_word(op, idx);
   endtask

   // Stop sending, wait for every owed result, then let the block go quiet
   task automatic settle(input int tail);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // Frame count write, only with the block idle
   task automatic write_frames(input logic [CNT_W-1:0] val);
      settle(QUIET_CYCLES);
      csr_valid         <= 1'b1;
      csr_frames_in_use <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_frames(val);
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   initial begin
      static int seg_plan [13] = '{1, 2, 64, 127, 0, -1, 5, 63, -1, 64, 33, -1, 100};
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty sweep, second chance, clamps, stale hand, ignored refs
      send_word(OP_VICTIM, 6'd63);
      send_word(OP_REFERENCE, 6'd63);
      send_word(OP_REFERENCE, 6'd0);
      send_word(OP_REFERENCE, 6'd1);
      send_word(OP_REFERENCE, 6'd2);
      send_word(OP_VICTIM, 6'd0);
      send_word(OP_VICTIM, 6'd21);
      write_frames(7'd127);
      send_word(OP_VICTIM, 6'd42);
      write_frames(7'd3);
      send_word(OP_REFERENCE, 6'd0);
      send_word(OP_REFERENCE, 6'd1);
      send_word(OP_REFERENCE, 6'd2);
      send_word(OP_REFERENCE, 6'd3);
      send_word(OP_REFERENCE, 6'd63);
      send_word(OP_VICTIM, 6'd0);
      send_word(OP_VICTIM, 6'd63);
      write_frames(7'd0);
      send_word(OP_REFERENCE, 6'd0);
      send_word(OP_VICTIM, 6'd0);
      send_word(OP_REFERENCE, 6'd1);
      send_word(OP_VICTIM, 6'd0);
      write_frames(7'd64);
      send_word(OP_VICTIM, 6'd0);

      // Random segments, one frame count each
      for (int seg = 0; seg < 13; seg++) begin
         if (seg_plan[seg] < 0)
            write_frames(CNT_W'($urandom_range(127)));
         else
            write_frames(CNT_W'(seg_plan[seg]));
         if (seg == 4) begin
            send_idle_pct = 45;
            recv_idle_pct <= 29;
         end else if (seg == 9) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
            -> stall_go;
         end
         repeat (SEG_WORDS) send_random();
      end

      settle(DRAIN_TAIL);
      $display("Ran %0d reference and %0d victim words across %0d frame-count writes,",
               sb.ref_words, sb.victim_words, csr_writes);
      $display("with random idling on both sides and a %0d-cycle result stall.", LONG_HOLD);
      if (sb.fault_count == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/cscv_pkg.sv
hdl/cscv_ctrl.sv
hdl/cscv_datapath.sv
hdl/clock_second_chance_victim_unit.sv
dv/clock_second_chance_victim_unit_tb.sv
